[src/dssm_pkg.sv]
// Shared types and constants for the dual stack shared memory block.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package dssm_pkg;

    // Field widths fixed by the word format
    localparam int ELEM_W    = 8;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int DEPTH_F_W = 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_POP  = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_item;    // capture the incoming word
        logic mem_read;     // issue the memory read for a pop or peek
        logic commit_exec;  // finish an item that needs no read
        logic commit_read;  // finish a pop or peek with the read data
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_read;      // held item is a pop or peek on a non-empty side
    } dp_stat_t;

endpackage

[src/dssm_ctrl.sv]
// Controller state machine for the dual stack shared memory block.
// Depends on dssm_pkg for the command and status structs.
module dssm_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output dssm_pkg::cmd_t    cmd,
    input  dssm_pkg::dp_stat_t stat
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // The output register can take a result when empty or being drained.
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    // Next state and commands.
    always_comb
    begin
        state_next       = state_reg;
        cmd.load_item    = 1'b0;
        cmd.mem_read     = 1'b0;
        cmd.commit_exec  = 1'b0;
        cmd.commit_read  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.is_read)
                begin
                    cmd.mem_read = 1'b1;
                    state_next   = S_READ;
                end
                else if (out_free)
                begin
                    cmd.commit_exec = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    cmd.commit_read = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output word valid flag.
    always_comb
    begin
        out_valid_next = (out_valid_reg && !m_tready) || cmd.commit_exec || cmd.commit_read;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[src/dssm_datapath.sv]
// Datapath of the dual stack shared memory block: item register, stack
// counts, the shared memory and the output word register. Uses dssm_pkg.
module dssm_datapath
#(
    parameter int DEPTH = 128
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  dssm_pkg::cmd_t                      cmd,
    output dssm_pkg::dp_stat_t                  stat,
    input  logic [dssm_pkg::OP_W-1:0]           in_op,
    input  logic                                in_side,
    input  logic [dssm_pkg::ELEM_W-1:0]         in_value,
    output logic [dssm_pkg::STATUS_W-1:0]       out_status,
    output logic [dssm_pkg::ELEM_W-1:0]         out_data,
    output logic [dssm_pkg::DEPTH_F_W-1:0]      out_left_depth,
    output logic [dssm_pkg::DEPTH_F_W-1:0]      out_right_depth
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [AW-1:0] ADDR_TOP = AW'(DEPTH - 1);
    localparam logic [SW-1:0] SUM_FULL = SW'(DEPTH);

    // Held item
    logic [dssm_pkg::OP_W-1:0]   op_reg;
    logic                        side_reg;
    logic [dssm_pkg::ELEM_W-1:0] value_reg;

    // Stack counts
    logic [CW-1:0] left_cnt_reg;
    logic [CW-1:0] left_cnt_next;
    logic [CW-1:0] right_cnt_reg;
    logic [CW-1:0] right_cnt_next;

    // Shared memory
    logic [dssm_pkg::ELEM_W-1:0] mem [DEPTH];
    logic [dssm_pkg::ELEM_W-1:0] rdata_reg;

    // Output word
    logic [dssm_pkg::STATUS_W-1:0]  status_reg;
    logic [dssm_pkg::STATUS_W-1:0]  status_next;
    logic [dssm_pkg::ELEM_W-1:0]    data_reg;
    logic [dssm_pkg::ELEM_W-1:0]    data_next;
    logic [dssm_pkg::DEPTH_F_W-1:0] left_depth_reg;
    logic [dssm_pkg::DEPTH_F_W-1:0] right_depth_reg;

    logic [CW-1:0] cur_cnt;
    logic [CW-1:0] cnt_m1;
    logic          full;
    logic          empty;
    logic          is_push;
    logic          is_access;
    logic          is_pop;
    logic          push_ok;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          load_out;

    // Decode the held item against the current counts.
    always_comb
    begin
        cur_cnt   = side_reg ? right_cnt_reg : left_cnt_reg;
        cnt_m1    = cur_cnt - CW'(1);
        full      = ({1'b0, left_cnt_reg} + {1'b0, right_cnt_reg}) >= SUM_FULL;
        empty     = (cur_cnt == '0);
        is_push   = (op_reg == dssm_pkg::OP_PUSH);
        is_pop    = (op_reg == dssm_pkg::OP_POP);
        is_access = is_pop || (op_reg == dssm_pkg::OP_PEEK);
        push_ok   = is_push && !full;
        stat.is_read = is_access && !empty;
        wr_addr   = side_reg ? (ADDR_TOP - cur_cnt[AW-1:0]) : cur_cnt[AW-1:0];
        rd_addr   = side_reg ? (ADDR_TOP - cnt_m1[AW-1:0]) : cnt_m1[AW-1:0];
        load_out  = cmd.commit_exec || cmd.commit_read;
    end

    // Count updates: a push grows its side, a pop shrinks it.
    always_comb
    begin
        left_cnt_next  = left_cnt_reg;
        right_cnt_next = right_cnt_reg;
        if (cmd.commit_exec && push_ok)
        begin
            if (side_reg)
            begin
                right_cnt_next = right_cnt_reg + CW'(1);
            end
            else
            begin
                left_cnt_next = left_cnt_reg + CW'(1);
            end
        end
        else if (cmd.commit_read && is_pop)
        begin
            if (side_reg)
            begin
                right_cnt_next = right_cnt_reg - CW'(1);
            end
            else
            begin
                left_cnt_next = left_cnt_reg - CW'(1);
            end
        end
    end

    // Result status and data.
    always_comb
    begin
        status_next = dssm_pkg::ST_OK;
        data_next   = '0;
        if (cmd.commit_read)
        begin
            data_next = rdata_reg;
        end
        else if (is_push && full)
        begin
            status_next = dssm_pkg::ST_FULL;
        end
        else if (is_access && empty)
        begin
            status_next = dssm_pkg::ST_EMPTY;
        end
    end

    // Item capture and output word.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg    <= in_op;
            side_reg  <= in_side;
            value_reg <= in_value;
        end
        if (load_out)
        begin
            status_reg      <= status_next;
            data_reg        <= data_next;
            left_depth_reg  <= dssm_pkg::DEPTH_F_W'(left_cnt_next);
            right_depth_reg <= dssm_pkg::DEPTH_F_W'(right_cnt_next);
        end
    end

    // Memory with one write and one registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.commit_exec && push_ok)
        begin
            mem[wr_addr] <= value_reg;
        end
        if (cmd.mem_read)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Stack counts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_cnt_reg  <= '0;
            right_cnt_reg <= '0;
        end
        else
        begin
            left_cnt_reg  <= left_cnt_next;
            right_cnt_reg <= right_cnt_next;
        end
    end

    assign out_status      = status_reg;
    assign out_data        = data_reg;
    assign out_left_depth  = left_depth_reg;
    assign out_right_depth = right_depth_reg;

endmodule

[src/dual_stack_shared_memory.sv]
// Top level of the dual stack shared memory block.
// Instantiates dssm_ctrl and dssm_datapath; uses dssm_pkg.

// Two stacks of bytes share one memory of DEPTH entries: the left stack
// grows up from entry 0, the right stack down from entry DEPTH-1. Each
// input word is a push, pop or peek on one side and yields exactly one
// output word with a status, the popped or peeked byte (zero otherwise)
// and both stack depths after the operation. A push or a refused
// operation goes from idle through the execute state and back to idle;
// a successful pop or peek also passes through the read state, for the
// registered read of the shared memory. A new word is accepted while
// the previous result still waits in the output register; a result stalls
// only when that register is still full at the end of the next item.
// Depths are reported modulo 256.
module dual_stack_shared_memory
#(
    parameter int DEPTH = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] value
    input  logic [2:0]  s_tuser,   // [1:0] op, [2] side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data, [15:8] left_depth, [23:16] right_depth
    output logic [1:0]  m_tuser    // [1:0] status
);

    dssm_pkg::cmd_t     cmd;
    dssm_pkg::dp_stat_t stat;

    logic [dssm_pkg::ELEM_W-1:0]    out_data;
    logic [dssm_pkg::DEPTH_F_W-1:0] out_left_depth;
    logic [dssm_pkg::DEPTH_F_W-1:0] out_right_depth;

    // Sequencing of each word.
    dssm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Counts, memory and result word.
    dssm_datapath #(.DEPTH(DEPTH)) u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_op           (s_tuser[1:0]),
        .in_side         (s_tuser[2]),
        .in_value        (s_tdata),
        .out_status      (m_tuser),
        .out_data        (out_data),
        .out_left_depth  (out_left_depth),
        .out_right_depth (out_right_depth)
    );

    assign m_tdata = {out_right_depth, out_left_depth, out_data};

endmodule

[src/dssm_checker.sv]
// Port-level checks for the dual stack shared memory block, bound to the
// top level. Uses dssm_pkg for the status codes.
module dssm_checker
#(
    parameter int DEPTH = 128
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // An accepted input word closes the input for the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input word accepted on consecutive cycles");

    // A presented output word stays until taken.
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word withdrawn before being taken");

    // A stalled output word keeps its contents.
    a_word_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // A refused operation returns zero data.
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != dssm_pkg::ST_OK) |-> (m_tdata[7:0] == 8'd0))
        else $error("refused operation returned non-zero data");

    // A full refusal means both stacks together fill the memory.
    a_full_sum: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == dssm_pkg::ST_FULL)
        |-> ((m_tdata[15:8] + m_tdata[23:16]) == 8'(DEPTH)))
        else $error("full status while the memory has free entries");

endmodule

bind dual_stack_shared_memory dssm_checker #(.DEPTH(DEPTH)) u_dssm_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
